>>> rtl/separable_box_blur_argb_unit_defines.svh
// Assertion macros shared by the box blur RTL.
// Depends on a clk and an active-low rst_n in the including module.
`ifndef SEPARABLE_BOX_BLUR_ARGB_UNIT_DEFINES_SVH
`define SEPARABLE_BOX_BLUR_ARGB_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBBA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SBBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sbba_pkg.sv
// Package for the separable box blur: item types, codes and defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sbba_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 8;
    localparam int MAX_HEIGHT     = 4096;
    localparam int ROW_W          = 12;

    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd768;
    localparam logic [3:0]  RST_BLUR_RADIUS  = 4'd2;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BLUR_RADIUS  = 2'd2;
    localparam logic [1:0] CFG_NONE         = 2'd3;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] in_alpha;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pix_item_t;

    typedef struct packed {
        logic [7:0] out_alpha;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_done;
    } res_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

>>> rtl/sbba_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sbba_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none
module sbba_div
    import sbba_pkg::*;
#(
    parameter int SW = 13,
    parameter int CW = 5
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [SW-1:0] dividend,
    input  wire logic [CW-1:0] divisor,
    output logic      [SW-1:0] quotient,
    output div_stat_t          stat
);
    localparam int NW = $clog2(SW + 1);

    logic [SW-1:0] q_reg;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] dv_reg;
    logic [NW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [CW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, q_reg[SW-1]};
    assign ge    = trial >= {1'b0, dv_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= NW'(SW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == NW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            dv_reg  <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? CW'(trial - {1'b0, dv_reg}) : CW'(trial);
            q_reg   <= {q_reg[SW-2:0], ge};
        end
    end

    assign quotient = q_reg;
    assign stat     = '{busy: busy_reg, done: done_reg};

endmodule
`default_nettype wire

>>> rtl/separable_box_blur_argb_unit.sv
// Top level of the separable box blur: row ring memory, sequencer, output register.
// Depends on sbba_pkg, sbba_div and the assertion macro header.
//
//  Channel | Signals                        | Transfer
//  pixel   | pix_valid, pix_ready, pix_item | valid and ready high at clk edge
//  result  | res_valid, res_ready, res_item | valid and ready high at clk edge
//  config  | cfg_we, cfg_index, cfg_data    | cfg_we high at clk edge
//
// An item that yields no result passes only the accept and check steps. One that yields a
// result is summed and divided row by row over the clipped window, then column-wise; the
// shared divider and the single memory read port serialize this work. The result register
// lets the next item enter while a result waits; a new result that finds it still full
// holds the block in its last step.
// There is no clearing pass after reset; the ring memory is never read before it is written.
`timescale 1ns / 1ps
`default_nettype none
`include "separable_box_blur_argb_unit_defines.svh"
module separable_box_blur_argb_unit
    import sbba_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pix_valid,
    output logic             pix_ready,
    input  wire pix_item_t   pix_item,
    output logic             res_valid,
    input  wire logic        res_ready,
    output res_item_t        res_item,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);
    localparam int RING_ROWS = 2 * MAX_RADIUS + 2;
    localparam int DEPTH     = RING_ROWS * MAX_WIDTH;
    localparam int AW        = $clog2(DEPTH);
    localparam int CLW       = $clog2(MAX_WIDTH);
    localparam int WW        = CLW + 1;
    localparam int GW        = $clog2(RING_ROWS);
    localparam int RW        = $clog2(MAX_RADIUS + 1);
    localparam int SW        = $clog2(255 * (2 * MAX_RADIUS + 1) + 1);
    localparam int CW        = $clog2(2 * MAX_RADIUS + 2);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHECK = 10'b0000000010,
        S_RD    = 10'b0000000100,
        S_ACC   = 10'b0000001000,
        S_HDIV  = 10'b0000010000,
        S_HWAIT = 10'b0000100000,
        S_VDIV  = 10'b0001000000,
        S_VWAIT = 10'b0010000000,
        S_ARD   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg;

    logic [10:0] fw_reg;
    logic [12:0] fh_reg;
    logic [3:0]  br_reg;

    logic [CLW-1:0]   in_col_reg, out_col_reg, nx_reg;
    logic [ROW_W-1:0] in_row_reg, out_row_reg, ny_reg;
    logic [GW-1:0]    in_ring_reg, out_ring_reg, ny_ring_reg;
    logic             in_done_reg;
    logic [1:0]       ch_reg;
    logic [SW-1:0]    hs_reg [3];
    logic [SW-1:0]    vs_reg [3];
    logic [CW-1:0]    hc_reg, vc_reg;
    logic [7:0]       avg_reg [3];
    logic [31:0]      rd_data_reg;
    logic             res_valid_reg;
    res_item_t        res_item_reg;
    logic [31:0]      mem [DEPTH];

    logic [WW-1:0]    w;
    logic [CLW-1:0]   wm1;
    logic [12:0]      h;
    logic [ROW_W-1:0] hm1;
    logic [RW-1:0]    r;
    logic [CLW:0]     sx;
    logic [ROW_W:0]   sy;
    logic [CLW-1:0]   rx, xlo;
    logic [ROW_W-1:0] ry, ylo;
    logic [GW:0]      ylo_t, ry_t;
    logic [GW-1:0]    ylo_ring, ry_ring, ny_ring_inc, in_ring_inc;
    logic             ready;
    logic             cfg_hit;
    logic             pix_acc, wr_en, rd_en, res_free, res_load, last_res;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [CLW-1:0]   rd_col;
    logic [GW-1:0]    rd_ring;
    logic             div_start;
    logic [SW-1:0]    div_dividend, div_q;
    logic [CW-1:0]    div_divisor;
    div_stat_t        div_stat;
    res_item_t        res_new;

    always_comb
    begin
        if (fw_reg == 11'd0)
            w = WW'(1);
        else if (32'(fw_reg) > MAX_WIDTH)
            w = WW'(MAX_WIDTH);
        else
            w = WW'(fw_reg);
        if (fh_reg == 13'd0)
            h = 13'd1;
        else if (32'(fh_reg) > MAX_HEIGHT)
            h = 13'(MAX_HEIGHT);
        else
            h = fh_reg;
        r = (32'(br_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(br_reg);
    end

    assign wm1 = CLW'(w - 1'b1);
    assign hm1 = ROW_W'(h - 1'b1);
    assign sx  = (CLW+1)'(out_col_reg) + (CLW+1)'(r);
    assign sy  = (ROW_W+1)'(out_row_reg) + (ROW_W+1)'(r);
    assign rx  = (sx < (CLW+1)'(wm1)) ? CLW'(sx) : wm1;
    assign ry  = (sy < (ROW_W+1)'(hm1)) ? ROW_W'(sy) : hm1;
    assign xlo = ((CLW+1)'(out_col_reg) > (CLW+1)'(r)) ? CLW'(out_col_reg - CLW'(r)) : '0;
    assign ylo = ((ROW_W+1)'(out_row_reg) > (ROW_W+1)'(r)) ?
                 ROW_W'(out_row_reg - ROW_W'(r)) : '0;

    always_comb
    begin
        ylo_t = (GW+1)'(out_ring_reg) + (GW+1)'(RING_ROWS) - (GW+1)'(out_row_reg - ylo);
        if (ylo_t >= (GW+1)'(RING_ROWS))
            ylo_t = ylo_t - (GW+1)'(RING_ROWS);
        ry_t = (GW+1)'(out_ring_reg) + (GW+1)'(ry - out_row_reg);
        if (ry_t >= (GW+1)'(RING_ROWS))
            ry_t = ry_t - (GW+1)'(RING_ROWS);
    end

    assign ylo_ring    = GW'(ylo_t);
    assign ry_ring     = GW'(ry_t);
    assign ny_ring_inc = (ny_ring_reg == GW'(RING_ROWS - 1)) ? '0 : ny_ring_reg + 1'b1;
    assign in_ring_inc = (in_ring_reg == GW'(RING_ROWS - 1)) ? '0 : in_ring_reg + 1'b1;

    assign ready = in_done_reg || (in_row_reg > ry) ||
                   ((in_row_reg == ry) && (in_col_reg > rx));

    assign cfg_hit   = cfg_we && (cfg_index != CFG_NONE);
    assign pix_ready = (state_reg == S_IDLE);
    assign pix_acc   = pix_valid && pix_ready;
    assign wr_en     = pix_acc && (pix_item.opcode == OP_PIXEL) && !in_done_reg;
    assign wr_addr   = AW'(in_ring_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);

    assign rd_en   = (state_reg == S_RD) || (state_reg == S_ARD);
    assign rd_col  = (state_reg == S_ARD) ? rx : nx_reg;
    assign rd_ring = (state_reg == S_ARD) ? ry_ring : ny_ring_reg;
    assign rd_addr = AW'(rd_ring) * AW'(MAX_WIDTH) + AW'(rd_col);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {pix_item.in_alpha, pix_item.in_red,
                             pix_item.in_green, pix_item.in_blue};
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign div_start    = (state_reg == S_HDIV) || (state_reg == S_VDIV);
    assign div_dividend = (state_reg == S_HDIV) ? hs_reg[ch_reg] : vs_reg[ch_reg];
    assign div_divisor  = (state_reg == S_HDIV) ? hc_reg : vc_reg;

    sbba_div #(
        .SW(SW),
        .CW(CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .stat     (div_stat)
    );

    assign res_free = !res_valid_reg || res_ready;
    assign res_load = (state_reg == S_OUT) && res_free;
    assign last_res = (out_col_reg == wm1) && (out_row_reg == hm1);
    assign res_new  = '{out_alpha: rd_data_reg[31:24], out_red: avg_reg[0],
                        out_green: avg_reg[1], out_blue: avg_reg[2], frame_done: last_res};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fw_reg        <= RST_FRAME_WIDTH;
            fh_reg        <= RST_FRAME_HEIGHT;
            br_reg        <= RST_BLUR_RADIUS;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_ring_reg   <= '0;
            in_done_reg   <= 1'b0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_ring_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_load || (res_valid_reg && !res_ready);
            if (cfg_hit)
            begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH:  fw_reg <= cfg_data[10:0];
                    CFG_FRAME_HEIGHT: fh_reg <= cfg_data;
                    CFG_BLUR_RADIUS:  br_reg <= cfg_data[3:0];
                    default:          br_reg <= br_reg;
                endcase
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_ring_reg  <= '0;
                in_done_reg  <= 1'b0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_ring_reg <= '0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pix_acc)
                    begin
                        state_reg <= S_CHECK;
                        if (wr_en && !cfg_hit)
                        begin
                            if ((CLW+1)'(in_col_reg) + 1'b1 >= w)
                            begin
                                in_col_reg <= '0;
                                if ((ROW_W+1)'(in_row_reg) + 1'b1 >= h)
                                begin
                                    in_row_reg  <= '0;
                                    in_ring_reg <= '0;
                                    in_done_reg <= 1'b1;
                                end
                                else
                                begin
                                    in_row_reg  <= in_row_reg + 1'b1;
                                    in_ring_reg <= in_ring_inc;
                                end
                            end
                            else
                                in_col_reg <= in_col_reg + 1'b1;
                        end
                    end
                end
                S_CHECK:
                    state_reg <= ready ? S_RD : S_IDLE;
                S_RD:
                    state_reg <= S_ACC;
                S_ACC:
                    state_reg <= (nx_reg == rx) ? S_HDIV : S_RD;
                S_HDIV:
                    state_reg <= S_HWAIT;
                S_HWAIT:
                begin
                    if (div_stat.done)
                    begin
                        if (ch_reg != 2'd2)
                            state_reg <= S_HDIV;
                        else
                            state_reg <= (ny_reg == ry) ? S_VDIV : S_RD;
                    end
                end
                S_VDIV:
                    state_reg <= S_VWAIT;
                S_VWAIT:
                begin
                    if (div_stat.done && (ch_reg == 2'd2))
                        state_reg <= S_ARD;
                    else if (div_stat.done)
                        state_reg <= S_VDIV;
                end
                S_ARD:
                    state_reg <= S_OUT;
                S_OUT:
                begin
                    if (res_free)
                    begin
                        state_reg <= S_IDLE;
                        if (!cfg_hit)
                        begin
                            if (last_res)
                            begin
                                in_col_reg   <= '0;
                                in_row_reg   <= '0;
                                in_ring_reg  <= '0;
                                in_done_reg  <= 1'b0;
                                out_col_reg  <= '0;
                                out_row_reg  <= '0;
                                out_ring_reg <= '0;
                            end
                            else if ((CLW+1)'(out_col_reg) + 1'b1 >= w)
                            begin
                                out_col_reg  <= '0;
                                out_row_reg  <= out_row_reg + 1'b1;
                                out_ring_reg <= (out_ring_reg == GW'(RING_ROWS - 1)) ?
                                                '0 : out_ring_reg + 1'b1;
                            end
                            else
                                out_col_reg <= out_col_reg + 1'b1;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_CHECK:
            begin
                nx_reg      <= xlo;
                ny_reg      <= ylo;
                ny_ring_reg <= ylo_ring;
                hc_reg      <= '0;
                vc_reg      <= '0;
                ch_reg      <= 2'd0;
                for (int i = 0; i < 3; i++)
                begin
                    hs_reg[i] <= '0;
                    vs_reg[i] <= '0;
                end
            end
            S_ACC:
            begin
                hs_reg[0] <= hs_reg[0] + SW'(rd_data_reg[23:16]);
                hs_reg[1] <= hs_reg[1] + SW'(rd_data_reg[15:8]);
                hs_reg[2] <= hs_reg[2] + SW'(rd_data_reg[7:0]);
                hc_reg    <= hc_reg + 1'b1;
                nx_reg    <= nx_reg + 1'b1;
            end
            S_HWAIT:
            begin
                if (div_stat.done)
                begin
                    vs_reg[ch_reg] <= vs_reg[ch_reg] + div_q;
                    if (ch_reg != 2'd2)
                        ch_reg <= ch_reg + 1'b1;
                    else
                    begin
                        ch_reg      <= 2'd0;
                        vc_reg      <= vc_reg + 1'b1;
                        nx_reg      <= xlo;
                        ny_reg      <= ny_reg + 1'b1;
                        ny_ring_reg <= ny_ring_inc;
                        hc_reg      <= '0;
                        for (int i = 0; i < 3; i++)
                            hs_reg[i] <= '0;
                    end
                end
            end
            S_VWAIT:
            begin
                if (div_stat.done)
                begin
                    avg_reg[ch_reg] <= div_q[7:0];
                    ch_reg          <= ch_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (res_free)
                    res_item_reg <= res_new;
            end
            default:
                ch_reg <= ch_reg;
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    `SBBA_ASSERT_SAME(a_div_start_idle, div_start, !div_stat.busy,
        "Divider started while busy.")
    `SBBA_ASSERT_NEXT(a_accept_to_check, pix_acc, state_reg == S_CHECK,
        "Accepted item did not enter the check step.")
    `SBBA_ASSERT_NEXT(a_frame_done_clears, res_load && last_res,
        (out_col_reg == '0) && (out_row_reg == '0) && !in_done_reg,
        "Frame counters not cleared after last result.")

endmodule
`default_nettype wire

>>> dv/separable_box_blur_argb_unit_test.sv
// Self-checking testbench for separable_box_blur_argb_unit: streams frames of ARGB pixels
// under random idling, predicts every blurred pixel and compares it field by field.
// Depends on sbba_pkg and the RTL of the block.
`timescale 1ns / 1ps
module separable_box_blur_argb_unit_test;
    import sbba_pkg::*;

    localparam int RING_ROWS = 2 * DEF_MAX_RADIUS + 2;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        pix_valid = 1'b0;
    logic        pix_ready;
    pix_item_t   pix_item = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    res_item_t   res_item;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_FRAME_WIDTH;
    logic [12:0] cfg_data = '0;

    separable_box_blur_argb_unit dut (
        .clk(clk), .rst_n(rst_n),
        .pix_valid(pix_valid), .pix_ready(pix_ready), .pix_item(pix_item),
        .res_valid(res_valid), .res_ready(res_ready), .res_item(res_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    logic [31:0] ring_mem [0:RING_ROWS*DEF_MAX_WIDTH-1];
    int unsigned reg_width, reg_height, reg_radius;
    int unsigned in_col, in_row, out_col, out_row;
    bit          input_done;
    res_item_t   expected_pixels [$];
    int          errors = 0;
    int          pixels_sent = 0;
    int          send_gap_max = 8;
    int          recv_gap_max = 8;

    function automatic int unsigned eff_width();
        if (reg_width == 0) return 1;
        return (reg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : reg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (reg_height == 0) return 1;
        return (reg_height > MAX_HEIGHT) ? MAX_HEIGHT : reg_height;
    endfunction

    function automatic int unsigned eff_radius();
        return (reg_radius > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : reg_radius;
    endfunction

    function automatic logic [31:0] ring_at(int unsigned col, int unsigned row);
        return ring_mem[(row % RING_ROWS) * DEF_MAX_WIDTH + (col % DEF_MAX_WIDTH)];
    endfunction

    function automatic void restart_frame();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        input_done = 1'b0;
    endfunction

    function automatic void apply_register(logic [1:0] idx, logic [12:0] val);
        if (idx == CFG_FRAME_WIDTH) reg_width = 32'(val[10:0]);
        else if (idx == CFG_FRAME_HEIGHT) reg_height = 32'(val[12:0]);
        else if (idx == CFG_BLUR_RADIUS) reg_radius = 32'(val[3:0]);
        else return;
        restart_frame();
    endfunction

    function automatic void predict_blur(pix_item_t it);
        int unsigned w, h, r, rx, ry, xlo, ylo, ny, nx, vcnt, hc;
        int unsigned vs [3];
        int unsigned hs [3];
        logic [31:0] p;
        res_item_t   res;
        w = eff_width();
        h = eff_height();
        r = eff_radius();
        if (it.opcode == OP_PIXEL && !input_done) begin
            ring_mem[(in_row % RING_ROWS) * DEF_MAX_WIDTH + (in_col % DEF_MAX_WIDTH)] =
                {it.in_alpha, it.in_red, it.in_green, it.in_blue};
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
                if (in_row >= h) begin
                    in_row = 0;
                    input_done = 1'b1;
                end
            end
        end
        rx = (out_col + r < w - 1) ? out_col + r : w - 1;
        ry = (out_row + r < h - 1) ? out_row + r : h - 1;
        if (!(input_done || in_row > ry || (in_row == ry && in_col > rx))) return;
        xlo = (out_col > r) ? out_col - r : 0;
        ylo = (out_row > r) ? out_row - r : 0;
        vs = '{0, 0, 0};
        vcnt = 0;
        for (ny = ylo; ny <= ry; ny++) begin
            hs = '{0, 0, 0};
            hc = 0;
            for (nx = xlo; nx <= rx; nx++) begin
                p = ring_at(nx, ny);
                hs[0] += 32'(p[23:16]);
                hs[1] += 32'(p[15:8]);
                hs[2] += 32'(p[7:0]);
                hc++;
            end
            for (int c = 0; c < 3; c++) vs[c] += hs[c] / hc;
            vcnt++;
        end
        p = ring_at(rx, ry);
        res.out_alpha  = p[31:24];
        res.out_red    = 8'(vs[0] / vcnt);
        res.out_green  = 8'(vs[1] / vcnt);
        res.out_blue   = 8'(vs[2] / vcnt);
        res.frame_done = (out_col == w - 1 && out_row == h - 1);
        expected_pixels.push_back(res);
        if (res.frame_done) begin
            restart_frame();
        end
        else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    function automatic pix_item_t random_pixel(logic op);
        pix_item_t it;
        it = pix_item_t'({1'b0, $urandom});
        it.opcode = op;
        return it;
    endfunction

    task automatic send_item(pix_item_t it);
        int gap;
        gap = $urandom_range(send_gap_max, 0);
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_item <= it;
        do @(posedge clk); while (!pix_ready);
        predict_blur(it);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [12:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        apply_register(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic setup_frame(logic [12:0] w, logic [12:0] h, logic [12:0] r);
        wait_idle();
        write_register(CFG_FRAME_WIDTH, w);
        write_register(CFG_FRAME_HEIGHT, h);
        write_register(CFG_BLUR_RADIUS, r);
    endtask

    // Sends count pixels; if the frame is in, drain ticks and stray pixels till it is out.
    task automatic stream_frame(int count, bit noisy);
        for (int i = 0; i < count; i++) begin
            if (noisy && $urandom_range(9, 0) == 0) send_item(random_pixel(OP_DRAIN));
            send_item(random_pixel(OP_PIXEL));
        end
        while (input_done) send_item(random_pixel($urandom_range(3, 0) != 0));
    endtask

    task automatic test_reset_defaults();
        for (int i = 0; i < 6; i++) send_item(random_pixel(OP_PIXEL));
        send_item(random_pixel(OP_DRAIN));
    endtask

    task automatic test_directed_cases();
        pix_item_t it;
        setup_frame(1, 1, 1);
        it = '{opcode: OP_PIXEL, in_alpha: 8'hff, in_red: 8'hff, in_green: 8'hff,
               in_blue: 8'hff};
        send_item(it);
        send_item(random_pixel(OP_PIXEL));
        send_item(random_pixel(OP_DRAIN));
        setup_frame(2, 2, 0);
        send_item('0);
        it.in_red = 8'h00;
        send_item(it);
        send_item(random_pixel(OP_PIXEL));
        send_item('{opcode: OP_PIXEL, in_alpha: 8'h00, in_red: 8'hff, in_green: 8'h00,
                    in_blue: 8'hff});
        setup_frame(0, 0, 15);
        send_item(random_pixel(OP_DRAIN));
        stream_frame(1, 1'b0);
        setup_frame(3, 2, 8);
        write_register(CFG_NONE, 13'h1fff);
        stream_frame(6, 1'b0);
        setup_frame(3, 3, 1);
        stream_frame(4, 1'b0);
        send_item(random_pixel(OP_DRAIN));
        wait_idle();
        write_register(CFG_FRAME_HEIGHT, 13'h1fff);
        for (int i = 0; i < 4; i++) send_item(random_pixel(OP_PIXEL));
    endtask

    task automatic test_wide_row();
        setup_frame(13'h7ff, 1, 1);
        stream_frame(48, 1'b0);
    endtask

    task automatic test_random_frames();
        int w, h, r, n;
        while (pixels_sent < 750) begin
            case ($urandom_range(3, 0))
                0: begin send_gap_max = 0; recv_gap_max = 0; end
                1: begin send_gap_max = 8; recv_gap_max = 0; end
                default: begin send_gap_max = 8; recv_gap_max = 8; end
            endcase
            if ($urandom_range(9, 0) < 7) begin
                r = $urandom_range(3, 0);
                w = $urandom_range(16, 1);
                h = $urandom_range(10, 1);
            end
            else begin
                r = $urandom_range(15, 4);
                w = $urandom_range(6, 1);
                h = $urandom_range(6, 1);
            end
            setup_frame(13'(w), 13'(h), 13'(r));
            n = w * h;
            if ($urandom_range(9, 0) == 0) n = $urandom_range(n, 0);
            stream_frame(n, 1'b1);
        end
    endtask

    initial begin
        forever begin
            int gap;
            gap = $urandom_range(recv_gap_max, 0);
            if (gap > 0) begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!(res_valid && rst_n));
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, res_item);
                errors++;
            end
            else begin
                res_item_t exp_res;
                exp_res = expected_pixels.pop_front();
                if (res_item.out_alpha !== exp_res.out_alpha ||
                    res_item.out_red !== exp_res.out_red ||
                    res_item.out_green !== exp_res.out_green ||
                    res_item.out_blue !== exp_res.out_blue ||
                    res_item.frame_done !== exp_res.frame_done) begin
                    $display("%0t: mismatch, expected %h, actual %h",
                             $time, exp_res, res_item);
                    errors++;
                end
            end
        end
    end

    initial begin
        reg_width = 32'(RST_FRAME_WIDTH);
        reg_height = 32'(RST_FRAME_HEIGHT);
        reg_radius = 32'(RST_BLUR_RADIUS);
        restart_frame();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_cases();
        test_wide_row();
        test_random_frames();
        wait_idle();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/sbba_pkg.sv
rtl/sbba_div.sv
rtl/separable_box_blur_argb_unit.sv
dv/separable_box_blur_argb_unit_test.sv
